>>> rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// shared constants, codes and link types for the sorted priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH  = 16;
    localparam int VAL_W  = 32;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int FILL_W = 5;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_POP    = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // operation broadcast to every cell
    typedef struct packed {
        logic                    ins;
        logic                    pop;
        logic signed [VAL_W-1:0] value;
    } t_cell_cmd;

    // what a cell shows its neighbors
    typedef struct packed {
        logic                    valid;
        logic                    ge;
        logic signed [VAL_W-1:0] value;
    } t_cell_link;

endpackage

>>> rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the descending sorted chain
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_cmd  i_cmd,
    input  t_cell_link i_prev,
    input  t_cell_link i_next,
    output t_cell_link o_link
);

    logic                    r_valid;
    logic signed [VAL_W-1:0] r_val;
    logic                    n_valid;
    logic signed [VAL_W-1:0] n_val;
    logic                    w_ge;

    // stored value stays in place when it is not below the new one
    assign w_ge = r_valid && (r_val >= i_cmd.value);

    always_comb begin
        n_valid = r_valid;
        n_val   = r_val;
        if (i_cmd.ins) begin
            if (!w_ge) begin
                if (i_prev.ge) begin
                    n_valid = 1'b1;
                    n_val   = i_cmd.value;
                end else begin
                    n_valid = i_prev.valid;
                    n_val   = i_prev.value;
                end
            end
        end else if (i_cmd.pop) begin
            n_valid = i_next.valid;
            n_val   = i_next.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_val <= n_val;
    end

    assign o_link = '{valid: r_valid, ge: w_ge, value: r_val};

endmodule

>>> rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// sorted register chain holding up to DEPTH signed values, insert or pop max
// ----------------------------------------------------------------------------
// a result is registered onto the master side in the cycle after its input transfer
// throughput: one item per cycle; every cell compares and shifts in the same
//   cycle, input ready follows the output register and the master tready
// reset: synchronous active-low clears the cell valid bits, the count and the
//   output valid; stored values need no reset
module sorted_priority_queue
    import spq_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    // slave side
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // [31:0] item_value
    input  logic         s_axis_tuser,   // [0] cmd
    // master side
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] popped_value, [63:32] max_value, [95:64] min_value,
    // [100:96] fill_count, [101] empty_flag, [103:102] status
    output logic [103:0] m_axis_tdata
);

    t_cell_cmd               w_cmd;
    t_cell_link              w_link [DEPTH];
    t_cell_link              w_prev [DEPTH];
    t_cell_link              w_next [DEPTH];

    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic signed [VAL_W-1:0] r_min;
    logic signed [VAL_W-1:0] n_min;

    logic                    r_out_valid;
    logic [103:0]            r_out_data;

    logic                    w_accept;
    logic                    w_full;
    logic                    w_empty;
    logic                    w_ins_ok;
    logic                    w_pop_ok;
    logic signed [VAL_W-1:0] w_item;
    t_cmd                    w_kind;
    t_status                 w_status;
    logic signed [VAL_W-1:0] w_popped;
    logic signed [VAL_W-1:0] w_max;
    logic signed [VAL_W-1:0] w_min;

    // input transfer whenever the output register is free or being drained
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_item  = s_axis_tdata;
    assign w_kind  = t_cmd'(s_axis_tuser);
    assign w_full  = (r_count == CNT_W'(DEPTH));
    assign w_empty = (r_count == '0);

    // dropped insert on full and pop on empty leave the chain untouched
    assign w_ins_ok = w_accept && (w_kind == CMD_INSERT) && !w_full;
    assign w_pop_ok = w_accept && (w_kind == CMD_POP) && !w_empty;

    assign w_cmd = '{ins: w_ins_ok, pop: w_pop_ok, value: w_item};

    // chain of cells, largest value in cell 0
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_head
            // head cell takes the new value when it is the largest
            assign w_prev[g] = '{valid: 1'b1, ge: 1'b1, value: '0};
        end else begin : g_mid
            assign w_prev[g] = w_link[g-1];
        end
        if (g == DEPTH - 1) begin : g_tail
            assign w_next[g] = '{valid: 1'b0, ge: 1'b0, value: '0};
        end else begin : g_body
            assign w_next[g] = w_link[g+1];
        end

        spq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_prev  (w_prev[g]),
            .i_next  (w_next[g]),
            .o_link  (w_link[g])
        );
    end

    // count, minimum tracker and result fields
    always_comb begin
        n_count  = r_count;
        n_min    = r_min;
        w_status = ST_OK;
        w_popped = '0;
        w_max    = w_link[0].value;
        if (w_ins_ok) begin
            n_count = r_count + CNT_W'(1);
            if (w_empty || (w_item < r_min)) begin
                n_min = w_item;
            end
            // new max is the head unless the item is above it
            if (!(w_link[0].valid && w_link[0].ge)) begin
                w_max = w_item;
            end
        end else if (w_pop_ok) begin
            n_count  = r_count - CNT_W'(1);
            w_popped = w_link[0].value;
            w_max    = w_link[1].value;
        end else if (w_accept) begin
            w_status = (w_kind == CMD_POP) ? ST_EMPTY : ST_FULL;
        end
        if (n_count == '0) begin
            w_max = '0;
            w_min = '0;
        end else begin
            w_min = n_min;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_min <= n_min;
        if (w_accept) begin
            r_out_data <= {w_status, (n_count == '0), FILL_W'(n_count),
                           w_min, w_max, w_popped};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // count never exceeds the chain length
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("count above depth");

    // head cell occupancy follows the count
    a_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_link[0].valid == (r_count != '0))
        else $error("head valid out of step with count");

    // tail cell occupied exactly when full
    a_tail_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_link[DEPTH-1].valid == w_full)
        else $error("tail valid out of step with full");

    // a pop on an empty queue leaves it empty
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_kind == CMD_POP) && w_empty) |=> (r_count == '0))
        else $error("pop on empty changed the count");

    // head keeps the largest value: cell 1 never above cell 0
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_link[1].valid |-> (w_link[1].value <= w_link[0].value))
        else $error("chain out of order");

endmodule

>>> tb/sv/sorted_priority_queue_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_tb
// self-checking bench: a sorted-array model predicts every result, a small
// scoreboard compares each master-side transfer field by field
// ----------------------------------------------------------------------------
module sorted_priority_queue_tb
    import spq_pkg::*;
;

    localparam int CLK_HALF    = 5;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 64;
    localparam int TAIL_CYCLES = 4;
    localparam int SEGMENT_LEN = 24;

    // one predicted result of the queue
    typedef struct {
        logic signed [VAL_W-1:0] popped;
        logic signed [VAL_W-1:0] max_v;
        logic signed [VAL_W-1:0] min_v;
        logic [FILL_W-1:0]       fill;
        logic                    empty;
        t_status                 status;
    } t_snapshot;

    // sorted-array model of the queue plus the results it still owes
    class pq_scoreboard;
        logic signed [VAL_W-1:0] cells [DEPTH];
        int                      stored_count;
        t_snapshot               expected_snapshots [$];
        int                      mismatch_count;

        function new();
            stored_count   = 0;
            mismatch_count = 0;
        endfunction

        function int pending();
            return expected_snapshots.size();
        endfunction

        function void report_mismatch(string msg);
            $display("[%0t] error: %s", $time, msg);
            mismatch_count++;
        endfunction

        // insert ahead of equal values, or pop the largest
        function void record_transfer(t_cmd cmd, logic signed [VAL_W-1:0] value);
            t_snapshot s;
            int        pos;
            int        k;
            s.popped = '0;
            s.status = ST_OK;
            if (cmd == CMD_INSERT) begin
                if (stored_count >= DEPTH) begin
                    s.status = ST_FULL;
                end else begin
                    pos = 0;
                    while (pos < stored_count && cells[pos] < value) pos++;
                    for (k = stored_count; k > pos; k--) cells[k] = cells[k-1];
                    cells[pos] = value;
                    stored_count++;
                end
            end else begin
                if (stored_count == 0) begin
                    s.status = ST_EMPTY;
                end else begin
                    stored_count--;
                    s.popped = cells[stored_count];
                end
            end
            s.max_v = (stored_count != 0) ? cells[stored_count-1] : '0;
            s.min_v = (stored_count != 0) ? cells[0] : '0;
            s.fill  = stored_count[FILL_W-1:0];
            s.empty = (stored_count == 0);
            expected_snapshots.push_back(s);
        endfunction

        function void compare_field(string name, logic [VAL_W-1:0] got,
                                    logic [VAL_W-1:0] exp);
            if (got !== exp)
                report_mismatch($sformatf("%s got %0h expected %0h", name, got, exp));
        endfunction

        function void check_result(logic [103:0] data);
            t_snapshot s;
            if (expected_snapshots.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected, data %h", data));
                return;
            end
            s = expected_snapshots.pop_front();
            compare_field("popped_value", data[31:0],   s.popped);
            compare_field("max_value",    data[63:32],  s.max_v);
            compare_field("min_value",    data[95:64],  s.min_v);
            compare_field("fill_count",   data[100:96], s.fill);
            compare_field("empty_flag",   data[101],    s.empty);
            compare_field("status",       data[103:102], s.status);
        endfunction
    endclass

    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata  = '0;   // [31:0] item_value
    logic         s_axis_tuser  = 1'b0; // [0] cmd
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // [31:0] popped_value, [63:32] max_value, [95:64] min_value,
    // [100:96] fill_count, [101] empty_flag, [103:102] status
    logic [103:0] m_axis_tdata;

    pq_scoreboard sb = new();

    int   src_idle_pct = 16;
    int   sink_idle_pct = 51;
    logic hold_req = 1'b0;   // toggled to ask the receiver for a long stall
    int   cycle_count = 0;

    sorted_priority_queue u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: check each transfer, then pick next cycle's tready
    logic hold_seen = 1'b0;
    int   hold_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata);
        end
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            // long stall so the queue backs up into its input
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // one input transfer; valid stays high afterwards unless the next call idles
    task automatic send_item(input t_cmd cmd, input logic signed [VAL_W-1:0] value);
        int gap;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct) gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.record_transfer(cmd, value);
    endtask

    // sender goes quiet until every predicted result has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // extremes, a narrow band for duplicates, or anything
    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2, 3:    return $urandom_range(15) - 8;
            default: return $urandom;
        endcase
    endfunction

    // segments lean toward filling, draining or balance so full and empty recur
    task automatic random_items(input int count);
        int insert_pct;
        int n;
        insert_pct = 50;
        for (n = 0; n < count; n++) begin
            if (n % SEGMENT_LEN == 0) begin
                case ($urandom_range(2))
                    0:       insert_pct = 85;
                    1:       insert_pct = 15;
                    default: insert_pct = 50;
                endcase
            end
            if ($urandom_range(99) < insert_pct) send_item(CMD_INSERT, pick_value());
            else send_item(CMD_POP, pick_value());
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // phase one: sender idles a little, receiver often
        src_idle_pct  = 16;
        sink_idle_pct = 51;

        // pop on empty queue, then extremes, zero, neighbors and duplicates
        send_item(CMD_POP, 32'sh1234_5678);
        send_item(CMD_INSERT, 32'sh7fff_ffff);
        send_item(CMD_INSERT, 32'sh8000_0000);
        send_item(CMD_INSERT, 32'sd0);
        send_item(CMD_INSERT, -32'sd1);
        send_item(CMD_INSERT, -32'sd1);
        send_item(CMD_INSERT, 32'sd1);
        send_item(CMD_POP, 32'sh0);
        // fill up, then insert into the full queue
        while (sb.stored_count < DEPTH) send_item(CMD_INSERT, pick_value());
        send_item(CMD_INSERT, 32'sh5a5a_5a5a);
        send_item(CMD_POP, 32'shffff_ffff);

        random_items(300);
        drain_results();

        // phase two: roles of the idling swapped
        src_idle_pct  = 51;
        sink_idle_pct = 16;
        random_items(310);
        drain_results();

        // phase three: back to back, with one long receiver stall in the middle
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        random_items(150);
        hold_req <= ~hold_req;
        random_items(160);
        drain_results();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.mismatch_count == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
tb/sv/sorted_priority_queue_tb.sv
